/* design/sphv_pkg.sv */
// Shared types, constants and table functions for the UV sphere vertex generator.
`default_nettype none

package sphv_pkg;

  // Default angle resolution (bits per turn) and output fraction bits
  localparam int ANGLE_BITS      = 16;
  localparam int COORD_FRAC_BITS = 14;

  // Field and register widths
  localparam int CNT_W  = 8;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // CORDIC: step count, datapath width, start value (gain in Q30)
  localparam int CORDIC_STEPS = 30;
  localparam int CW           = 34;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  // Register indexes on the configuration port
  localparam logic REG_STACK_COUNT  = 1'b0;
  localparam logic REG_SECTOR_COUNT = 1'b1;

  // Reset values of the count registers
  localparam logic [CNT_W-1:0] STACK_COUNT_RST  = 8'd20;
  localparam logic [CNT_W-1:0] SECTOR_COUNT_RST = 8'd20;

  typedef struct packed {
    logic [CNT_W-1:0] stack_index;
    logic [CNT_W-1:0] sector_index;
  } in_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
  } out_t;

  typedef struct packed {
    logic                 flip;
    logic signed [CW-1:0] z;
  } prep_t;

  // Arctangent of 2^-k as a 32-bit fraction of a turn
  function automatic logic [31:0] atan_turn(input int unsigned k);
    logic [31:0] r;
    begin
      case (k)
        0:  r = 32'h20000000;
        1:  r = 32'h12E4051E;
        2:  r = 32'h09FB385B;
        3:  r = 32'h051111D4;
        4:  r = 32'h028B0D43;
        5:  r = 32'h0145D7E1;
        6:  r = 32'h00A2F61E;
        7:  r = 32'h00517C55;
        8:  r = 32'h0028BE53;
        9:  r = 32'h00145F2F;
        10: r = 32'h000A2F98;
        11: r = 32'h000517CC;
        12: r = 32'h00028BE6;
        13: r = 32'h000145F3;
        14: r = 32'h0000A2FA;
        15: r = 32'h0000517D;
        16: r = 32'h000028BE;
        17: r = 32'h0000145F;
        18: r = 32'h00000A30;
        19: r = 32'h00000518;
        20: r = 32'h0000028C;
        21: r = 32'h00000146;
        22: r = 32'h000000A3;
        23: r = 32'h00000051;
        24: r = 32'h00000029;
        25: r = 32'h00000014;
        26: r = 32'h0000000A;
        27: r = 32'h00000005;
        28: r = 32'h00000003;
        29: r = 32'h00000001;
        default: r = 32'h0;
      endcase
      return r;
    end
  endfunction

  // Fold a 32-bit turn into [-1/4, 1/4) and flag the half-turn flip
  function automatic prep_t cordic_prep(input logic [31:0] a);
    logic [31:0] s;
    logic [31:0] r;
    prep_t       p;
    begin
      s      = a + 32'h4000_0000;
      p.flip = s[31];
      r      = p.flip ? (a - 32'h8000_0000) : a;
      p.z    = CW'($signed(r));
      return p;
    end
  endfunction

endpackage

`default_nettype wire

/* design/sphv_div_cell.sv */
// One restoring-division cell: resolves one quotient bit for both angle dividers.
`default_nettype none

module sphv_div_cell #(
  parameter int NW  = 25,
  parameter int QW  = 17,
  parameter int BIT = 0
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          vld_i,
  input  wire logic [8:0]    den_st_i,
  input  wire logic [8:0]    den_se_i,
  input  wire logic [NW-1:0] num_st_i,
  input  wire logic [8:0]    rem_st_i,
  input  wire logic [QW-1:0] quo_st_i,
  input  wire logic [NW-1:0] num_se_i,
  input  wire logic [8:0]    rem_se_i,
  input  wire logic [QW-1:0] quo_se_i,
  output logic               vld_o,
  output logic [NW-1:0]      num_st_o,
  output logic [8:0]         rem_st_o,
  output logic [QW-1:0]      quo_st_o,
  output logic [NW-1:0]      num_se_o,
  output logic [8:0]         rem_se_o,
  output logic [QW-1:0]      quo_se_o
);

  logic [9:0]    t_st, t_se;
  logic          ge_st, ge_se;
  logic [8:0]    rem_st_d, rem_se_d;
  logic [QW-1:0] quo_st_d, quo_se_d;
  logic          vld_q;
  logic [NW-1:0] num_st_q, num_se_q;
  logic [8:0]    rem_st_q, rem_se_q;
  logic [QW-1:0] quo_st_q, quo_se_q;

  // Shift in the next numerator bit, subtract the divisor where it fits
  always_comb begin
    t_st     = {rem_st_i, num_st_i[BIT]};
    t_se     = {rem_se_i, num_se_i[BIT]};
    ge_st    = t_st >= {1'b0, den_st_i};
    ge_se    = t_se >= {1'b0, den_se_i};
    rem_st_d = ge_st ? 9'(t_st - {1'b0, den_st_i}) : t_st[8:0];
    rem_se_d = ge_se ? 9'(t_se - {1'b0, den_se_i}) : t_se[8:0];
    quo_st_d = quo_st_i;
    quo_se_d = quo_se_i;
    quo_st_d[BIT] = ge_st;
    quo_se_d[BIT] = ge_se;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  // Advance payload with the pipeline
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_st_q <= num_st_i;
      rem_st_q <= rem_st_d;
      quo_st_q <= quo_st_d;
      num_se_q <= num_se_i;
      rem_se_q <= rem_se_d;
      quo_se_q <= quo_se_d;
    end
  end

  assign vld_o    = vld_q;
  assign num_st_o = num_st_q;
  assign rem_st_o = rem_st_q;
  assign quo_st_o = quo_st_q;
  assign num_se_o = num_se_q;
  assign rem_se_o = rem_se_q;
  assign quo_se_o = quo_se_q;

endmodule

`default_nettype wire

/* design/sphv_cordic_cell.sv */
// One CORDIC rotation cell, applied to the stack and the sector angle side by side.
`default_nettype none

module sphv_cordic_cell #(
  parameter int STEP = 0
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          vld_i,
  input  wire logic signed [sphv_pkg::CW-1:0] x_st_i,
  input  wire logic signed [sphv_pkg::CW-1:0] y_st_i,
  input  wire logic signed [sphv_pkg::CW-1:0] z_st_i,
  input  wire logic                          flip_st_i,
  input  wire logic signed [sphv_pkg::CW-1:0] x_se_i,
  input  wire logic signed [sphv_pkg::CW-1:0] y_se_i,
  input  wire logic signed [sphv_pkg::CW-1:0] z_se_i,
  input  wire logic                          flip_se_i,
  output logic                               vld_o,
  output logic signed [sphv_pkg::CW-1:0]     x_st_o,
  output logic signed [sphv_pkg::CW-1:0]     y_st_o,
  output logic signed [sphv_pkg::CW-1:0]     z_st_o,
  output logic                               flip_st_o,
  output logic signed [sphv_pkg::CW-1:0]     x_se_o,
  output logic signed [sphv_pkg::CW-1:0]     y_se_o,
  output logic signed [sphv_pkg::CW-1:0]     z_se_o,
  output logic                               flip_se_o
);

  localparam int CW = sphv_pkg::CW;
  localparam logic [31:0] ATAN_U = sphv_pkg::atan_turn(STEP);
  localparam logic signed [CW-1:0] ATAN = $signed(CW'(ATAN_U));

  logic signed [CW-1:0] x_st_d, y_st_d, z_st_d, x_se_d, y_se_d, z_se_d;
  logic                 vld_q, flip_st_q, flip_se_q;
  logic signed [CW-1:0] x_st_q, y_st_q, z_st_q, x_se_q, y_se_q, z_se_q;

  // Rotate toward zero residual angle; shifts floor toward minus infinity
  always_comb begin
    if (!z_st_i[CW-1]) begin
      x_st_d = x_st_i - (y_st_i >>> STEP);
      y_st_d = y_st_i + (x_st_i >>> STEP);
      z_st_d = z_st_i - ATAN;
    end else begin
      x_st_d = x_st_i + (y_st_i >>> STEP);
      y_st_d = y_st_i - (x_st_i >>> STEP);
      z_st_d = z_st_i + ATAN;
    end
    if (!z_se_i[CW-1]) begin
      x_se_d = x_se_i - (y_se_i >>> STEP);
      y_se_d = y_se_i + (x_se_i >>> STEP);
      z_se_d = z_se_i - ATAN;
    end else begin
      x_se_d = x_se_i + (y_se_i >>> STEP);
      y_se_d = y_se_i - (x_se_i >>> STEP);
      z_se_d = z_se_i + ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_st_q    <= x_st_d;
      y_st_q    <= y_st_d;
      z_st_q    <= z_st_d;
      flip_st_q <= flip_st_i;
      x_se_q    <= x_se_d;
      y_se_q    <= y_se_d;
      z_se_q    <= z_se_d;
      flip_se_q <= flip_se_i;
    end
  end

  assign vld_o     = vld_q;
  assign x_st_o    = x_st_q;
  assign y_st_o    = y_st_q;
  assign z_st_o    = z_st_q;
  assign flip_st_o = flip_st_q;
  assign x_se_o    = x_se_q;
  assign y_se_o    = y_se_q;
  assign z_se_o    = z_se_q;
  assign flip_se_o = flip_se_q;

endmodule

`default_nettype wire

/* design/uv_sphere_vertex_generator_unit.sv */
// Top level of the UV sphere vertex generator: config port, cell chains, output buffer.
`default_nettype none

// Takes one grid point (stack, sector) per cycle while in_stall_o is low and
// returns its unit-sphere position in signed fixed point. Throughput is one
// point per clock when not stalled; a point passes ANGLE_BITS+1 divider cells,
// then 30 CORDIC cells, then one multiply stage and the output buffer. A
// two-entry output buffer absorbs a stall on the result side; in_stall_o rises
// only when both entries are full. Counts must be written while no point is in
// flight.
module uv_sphere_vertex_generator_unit #(
  parameter int ANGLE_BITS      = sphv_pkg::ANGLE_BITS,
  parameter int COORD_FRAC_BITS = sphv_pkg::COORD_FRAC_BITS
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire sphv_pkg::in_t               in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output sphv_pkg::out_t                   out_data_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [sphv_pkg::ADDR_W-1:0] paddr,
  input  wire logic [sphv_pkg::DATA_W-1:0] pwdata,
  output logic [sphv_pkg::DATA_W-1:0]      prdata,
  output logic                             pready
);

  localparam int CW  = sphv_pkg::CW;
  localparam int CS  = sphv_pkg::CORDIC_STEPS;
  localparam int QW  = ANGLE_BITS + 1;
  localparam int NW  = sphv_pkg::CNT_W + ANGLE_BITS + 1;
  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
  localparam int SH_P = 60 - COORD_FRAC_BITS;
  localparam int SH_Z = 30 - COORD_FRAC_BITS;
  localparam logic signed [63:0] RND_P = 64'sd1 <<< (SH_P - 1);
  localparam logic signed [63:0] RND_Z = (SH_Z > 0) ? (64'sd1 <<< (SH_Z - 1)) : 64'sd0;
  localparam logic signed [63:0] ONE_C = 64'sd1 <<< COORD_FRAC_BITS;
  localparam logic signed [63:0] MAX16 = 64'sd32767;
  localparam logic signed [63:0] MIN16 = -64'sd32768;

  logic [sphv_pkg::CNT_W-1:0] stack_count_q, sector_count_q;
  logic [sphv_pkg::CNT_W-1:0] stc, sec, i_cl, j_cl;
  logic [8:0]                 den_st, den_se;
  logic                       en;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stack_count_q  <= sphv_pkg::STACK_COUNT_RST;
      sector_count_q <= sphv_pkg::SECTOR_COUNT_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        sphv_pkg::REG_STACK_COUNT:  stack_count_q  <= pwdata[sphv_pkg::CNT_W-1:0];
        sphv_pkg::REG_SECTOR_COUNT: sector_count_q <= pwdata[sphv_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      sphv_pkg::REG_STACK_COUNT:  prdata = sphv_pkg::DATA_W'(stack_count_q);
      sphv_pkg::REG_SECTOR_COUNT: prdata = sphv_pkg::DATA_W'(sector_count_q);
      default:                    prdata = '0;
    endcase
  end
  assign pready = 1'b1;

  // Treat a zero count as one, clamp indexes to their counts
  always_comb begin
    stc    = (stack_count_q == '0) ? 8'd1 : stack_count_q;
    sec    = (sector_count_q == '0) ? 8'd1 : sector_count_q;
    i_cl   = (in_data_i.stack_index > stc) ? stc : in_data_i.stack_index;
    j_cl   = (in_data_i.sector_index > sec) ? sec : in_data_i.sector_index;
    den_st = {stc, 1'b0};
    den_se = {sec, 1'b0};
  end

  // Divider chain: rounded index * half turn / count (stack), index * turn / count (sector)
  logic          d_vld    [0:QW];
  logic [NW-1:0] d_num_st [0:QW];
  logic [8:0]    d_rem_st [0:QW];
  logic [QW-1:0] d_quo_st [0:QW];
  logic [NW-1:0] d_num_se [0:QW];
  logic [8:0]    d_rem_se [0:QW];
  logic [QW-1:0] d_quo_se [0:QW];

  assign d_vld[0]    = in_valid_i;
  assign d_num_st[0] = (NW'(i_cl) << ANGLE_BITS) + NW'(stc);
  assign d_num_se[0] = (NW'(j_cl) << (ANGLE_BITS + 1)) + NW'(sec);
  assign d_rem_st[0] = {1'b0, d_num_st[0][NW-1:QW]};
  assign d_rem_se[0] = {1'b0, d_num_se[0][NW-1:QW]};
  assign d_quo_st[0] = '0;
  assign d_quo_se[0] = '0;

  for (genvar k = 0; k < QW; k++) begin : g_div
    sphv_div_cell #(.NW(NW), .QW(QW), .BIT(QW - 1 - k)) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .vld_i    (d_vld[k]),
      .den_st_i (den_st),
      .den_se_i (den_se),
      .num_st_i (d_num_st[k]),
      .rem_st_i (d_rem_st[k]),
      .quo_st_i (d_quo_st[k]),
      .num_se_i (d_num_se[k]),
      .rem_se_i (d_rem_se[k]),
      .quo_se_i (d_quo_se[k]),
      .vld_o    (d_vld[k+1]),
      .num_st_o (d_num_st[k+1]),
      .rem_st_o (d_rem_st[k+1]),
      .quo_st_o (d_quo_st[k+1]),
      .num_se_o (d_num_se[k+1]),
      .rem_se_o (d_rem_se[k+1]),
      .quo_se_o (d_quo_se[k+1])
    );
  end

  // Turn quotients into phases and fold them for the CORDIC
  logic [ANGLE_BITS-1:0] st_ph, se_ph;
  sphv_pkg::prep_t       prep_st, prep_se;

  always_comb begin
    st_ph   = QUARTER - d_quo_st[QW][ANGLE_BITS-1:0];
    se_ph   = d_quo_se[QW][ANGLE_BITS-1:0];
    prep_st = sphv_pkg::cordic_prep({st_ph, (32 - ANGLE_BITS)'(0)});
    prep_se = sphv_pkg::cordic_prep({se_ph, (32 - ANGLE_BITS)'(0)});
  end

  // CORDIC chain
  logic                 c_vld     [0:CS];
  logic signed [CW-1:0] c_x_st    [0:CS];
  logic signed [CW-1:0] c_y_st    [0:CS];
  logic signed [CW-1:0] c_z_st    [0:CS];
  logic                 c_flip_st [0:CS];
  logic signed [CW-1:0] c_x_se    [0:CS];
  logic signed [CW-1:0] c_y_se    [0:CS];
  logic signed [CW-1:0] c_z_se    [0:CS];
  logic                 c_flip_se [0:CS];

  assign c_vld[0]     = d_vld[QW];
  assign c_x_st[0]    = sphv_pkg::CORDIC_GAIN;
  assign c_y_st[0]    = '0;
  assign c_z_st[0]    = prep_st.z;
  assign c_flip_st[0] = prep_st.flip;
  assign c_x_se[0]    = sphv_pkg::CORDIC_GAIN;
  assign c_y_se[0]    = '0;
  assign c_z_se[0]    = prep_se.z;
  assign c_flip_se[0] = prep_se.flip;

  for (genvar k = 0; k < CS; k++) begin : g_cordic
    sphv_cordic_cell #(.STEP(k)) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .vld_i     (c_vld[k]),
      .x_st_i    (c_x_st[k]),
      .y_st_i    (c_y_st[k]),
      .z_st_i    (c_z_st[k]),
      .flip_st_i (c_flip_st[k]),
      .x_se_i    (c_x_se[k]),
      .y_se_i    (c_y_se[k]),
      .z_se_i    (c_z_se[k]),
      .flip_se_i (c_flip_se[k]),
      .vld_o     (c_vld[k+1]),
      .x_st_o    (c_x_st[k+1]),
      .y_st_o    (c_y_st[k+1]),
      .z_st_o    (c_z_st[k+1]),
      .flip_st_o (c_flip_st[k+1]),
      .x_se_o    (c_x_se[k+1]),
      .y_se_o    (c_y_se[k+1]),
      .z_se_o    (c_z_se[k+1]),
      .flip_se_o (c_flip_se[k+1])
    );
  end

  // Undo the half-turn fold and form the products
  logic signed [CW-1:0] cst_w, sst_w, cse_w, sse_w;
  logic signed [31:0]   cst_v, sst_v, cse_v, sse_v;
  logic signed [63:0]   px_d, py_d;
  logic                 pv_q;
  logic signed [63:0]   px_q, py_q;
  logic signed [31:0]   sz_q;

  always_comb begin
    cst_w = c_flip_st[CS] ? -c_x_st[CS] : c_x_st[CS];
    sst_w = c_flip_st[CS] ? -c_y_st[CS] : c_y_st[CS];
    cse_w = c_flip_se[CS] ? -c_x_se[CS] : c_x_se[CS];
    sse_w = c_flip_se[CS] ? -c_y_se[CS] : c_y_se[CS];
    cst_v = cst_w[31:0];
    sst_v = sst_w[31:0];
    cse_v = cse_w[31:0];
    sse_v = sse_w[31:0];
    px_d  = 64'(cst_v) * 64'(cse_v);
    py_d  = 64'(cst_v) * 64'(sse_v);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else if (en) begin
      pv_q <= c_vld[CS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q <= px_d;
      py_q <= py_d;
      sz_q <= sst_v;
    end
  end

  // Clamp to the unit range, then to 16 bits
  function automatic logic signed [15:0] clamp_q(input logic signed [63:0] v);
    logic signed [63:0] w;
    begin
      w = v;
      if (w > ONE_C) w = ONE_C;
      if (w < -ONE_C) w = -ONE_C;
      if (w > MAX16) w = MAX16;
      if (w < MIN16) w = MIN16;
      return w[15:0];
    end
  endfunction

  sphv_pkg::out_t res;

  always_comb begin
    res.pos_x = clamp_q((px_q + RND_P) >>> SH_P);
    res.pos_y = clamp_q((py_q + RND_P) >>> SH_P);
    res.pos_z = clamp_q((64'(sz_q) + RND_Z) >>> SH_Z);
  end

  // Two-entry output buffer; the pipeline holds only when both are full
  sphv_pkg::out_t head_q, tail_q;
  logic           head_vld_q, tail_vld_q;
  logic           push, pop;

  assign en   = !tail_vld_q;
  assign push = pv_q && en;
  assign pop  = head_vld_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      tail_vld_q <= 1'b0;
    end else begin
      if (!head_vld_q || pop) begin
        head_vld_q <= tail_vld_q || push;
        tail_vld_q <= 1'b0;
      end else if (push) begin
        tail_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!head_vld_q || pop) begin
      head_q <= tail_vld_q ? tail_q : res;
    end else if (push) begin
      tail_q <= res;
    end
  end

  assign in_stall_o  = !en;
  assign out_valid_o = head_vld_q;
  assign out_data_o  = head_q;

  // Buffer fills from the head
  a_tail_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_vld_q |-> head_vld_q)
    else $error("tail entry valid while head is empty");

  // A full buffer under stall stays full and blocks the chain
  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tail_vld_q && out_stall_i) |=> (tail_vld_q && in_stall_o))
    else $error("full buffer lost an entry while stalled");

  // A finished point lands in an empty buffer at once
  a_land: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pv_q && !head_vld_q) |=> head_vld_q)
    else $error("finished point not moved into the output buffer");

  // z stays within the unit range
  a_z_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_vld_q |-> ((64'(head_q.pos_z) <= ONE_C) && (64'(head_q.pos_z) >= -ONE_C)))
    else $error("pos_z outside the unit range");

endmodule

`default_nettype wire
